// ===== hw/rtl/scst_pkg.sv =====
`default_nettype none

package scst_pkg;

    localparam int SLOTS      = 32;
    localparam int KEY_BITS   = 24;
    localparam int VALUE_BITS = 16;
    localparam int LEVEL_BITS = 6;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);

    typedef logic [SLOT_W-1:0]     slot_idx_t;
    typedef logic [CNT_W-1:0]      scan_cnt_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [VALUE_BITS-1:0] val_t;
    typedef logic [LEVEL_BITS-1:0] level_t;

    localparam level_t MAX_DEPTH = '1;

    typedef enum logic [2:0] {
        OP_PUSH          = 3'd0,
        OP_POP           = 3'd1,
        OP_LOOKUP        = 3'd2,
        OP_DELETE        = 3'd3,
        OP_CREATE        = 3'd4,
        OP_GET_OR_CREATE = 3'd5,
        OP_CREATE_FUNC   = 3'd6
    } op_e;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_DEPTH = 2'd2
    } err_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_e;

    typedef struct packed {
        logic [2:0]  operation;
        logic [23:0] key;
        logic [15:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [4:0]  slot;
        logic [15:0] value_out;
        logic        is_function;
        logic [5:0]  entry_level;
        logic        freed_valid;
        logic [15:0] freed_node;
        logic [1:0]  error;
        logic [5:0]  depth_out;
    } out_item_t;

    // One stored entry; the valid mark lives in flip-flops beside the RAM.
    typedef struct packed {
        logic   func;
        level_t level;
        key_t   key;
        val_t   value;
    } entry_t;

    typedef struct packed {
        logic      rd_en;
        slot_idx_t rd_addr;
        logic      wr_en;
        slot_idx_t wr_addr;
        entry_t    wr_data;
    } ram_req_t;

    // Compare results for the entry returned by the RAM in this cycle.
    typedef struct packed {
        logic live_key;
        logic live_cur;
    } entry_cmp_t;

    // Matches collected over one scan of the table.
    typedef struct packed {
        logic      cur1_f;
        slot_idx_t cur1;
        logic      cur1_fn;
        val_t      cur1_val;
        logic      cur2_f;
        slot_idx_t cur2;
        logic      zero1_f;
        slot_idx_t zero1;
        logic      zero1_fn;
        val_t      zero1_val;
        logic      zero2_f;
        slot_idx_t zero2;
        logic      free_f;
        slot_idx_t free_idx;
    } match_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scst_entry_ram.sv =====
`default_nettype none

module scst_entry_ram (
    input  wire               aclk,
    input  scst_pkg::ram_req_t ram_req,
    output scst_pkg::entry_t   rd_data
);
    import scst_pkg::*;

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ram_req.wr_en) begin
            mem[ram_req.wr_addr] <= ram_req.wr_data;
        end
        if (ram_req.rd_en) begin
            rd_data_reg <= mem[ram_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scst_match.sv =====
`default_nettype none

module scst_match (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  clear,
    input  wire                  rd_vld,
    input  scst_pkg::slot_idx_t  rd_idx,
    input  scst_pkg::entry_t     rd_entry,
    input  wire                  rd_entry_valid,
    input  scst_pkg::key_t       key,
    input  scst_pkg::level_t     depth,
    output scst_pkg::entry_cmp_t cmp,
    output scst_pkg::match_t     match
);
    import scst_pkg::*;

    match_t match_reg;
    match_t match_next;
    logic   key_hit;
    logic   cur_hit;
    logic   zero_hit;

    assign key_hit      = rd_entry_valid && (rd_entry.key == key);
    assign cmp.live_key = key_hit;
    assign cmp.live_cur = rd_entry_valid && (rd_entry.level == depth);
    assign cur_hit      = rd_vld && key_hit && (rd_entry.level == depth);
    assign zero_hit     = rd_vld && key_hit && (rd_entry.level == '0);

    // The first two hits at the current level and at level zero are kept so that a
    // second lookup, after the first hit is dropped, needs no further pass.
    always_comb begin
        match_next = match_reg;
        if (clear) begin
            match_next = '0;
        end else begin
            if (cur_hit) begin
                if (!match_reg.cur1_f) begin
                    match_next.cur1_f   = 1'b1;
                    match_next.cur1     = rd_idx;
                    match_next.cur1_fn  = rd_entry.func;
                    match_next.cur1_val = rd_entry.value;
                end else if (!match_reg.cur2_f) begin
                    match_next.cur2_f = 1'b1;
                    match_next.cur2   = rd_idx;
                end
            end
            if (zero_hit) begin
                if (!match_reg.zero1_f) begin
                    match_next.zero1_f   = 1'b1;
                    match_next.zero1     = rd_idx;
                    match_next.zero1_fn  = rd_entry.func;
                    match_next.zero1_val = rd_entry.value;
                end else if (!match_reg.zero2_f) begin
                    match_next.zero2_f = 1'b1;
                    match_next.zero2   = rd_idx;
                end
            end
            if (rd_vld && !rd_entry_valid && !match_reg.free_f) begin
                match_next.free_f   = 1'b1;
                match_next.free_idx = rd_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= '0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scst_ctrl.sv =====
`default_nettype none

module scst_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  scst_pkg::in_item_t   s_payload,
    input  wire                  out_free,
    output logic                 res_valid,
    output scst_pkg::out_item_t  res,
    output scst_pkg::ram_req_t   ram_req,
    input  scst_pkg::entry_t     rd_data
);
    import scst_pkg::*;

    state_e     state_reg;
    state_e     state_next;
    logic [2:0] op_reg;
    key_t       key_reg;
    val_t       val_reg;
    level_t     depth_reg;
    level_t     depth_next;
    scan_cnt_t  cnt_reg;
    logic       rd_vld_reg;
    slot_idx_t  rd_idx_reg;
    logic [SLOTS-1:0] valid_reg;

    entry_cmp_t cmp;
    match_t     match;

    logic       accept;
    logic       dec_go;
    logic       issue;
    logic       scan_clr;

    logic       h1_cur;
    logic       h1_f;
    slot_idx_t  h1_idx;
    logic       h1_fn;
    val_t       h1_val;
    level_t     h1_level;
    logic       hit2_cur;
    logic       hit2_f;
    slot_idx_t  hit2_idx;
    level_t     hit2_level;
    logic       free2_f;
    slot_idx_t  free2_idx;

    logic       wr_en;
    slot_idx_t  wr_addr;
    entry_t     wr_data;
    logic       clr_h1;
    logic       set_en;
    slot_idx_t  set_idx;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign res_valid = (state_reg == ST_DECIDE);
    assign dec_go    = res_valid && out_free;
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg < CNT_W'(SLOTS));

    scst_match u_match (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .clear          (accept),
        .rd_vld         (rd_vld_reg),
        .rd_idx         (rd_idx_reg),
        .rd_entry       (rd_data),
        .rd_entry_valid (valid_reg[rd_idx_reg]),
        .key            (key_reg),
        .depth          (depth_reg),
        .cmp            (cmp),
        .match          (match)
    );

    // Pop and delete drop entries as the scan returns them.
    always_comb begin
        scan_clr = 1'b0;
        if (rd_vld_reg) begin
            case (op_e'(op_reg))
                OP_POP:    scan_clr = cmp.live_cur;
                OP_DELETE: scan_clr = cmp.live_key;
                default:   scan_clr = 1'b0;
            endcase
        end
    end

    // First lookup: current level, then level zero when the depth is above zero.
    assign h1_cur   = match.cur1_f;
    assign h1_f     = h1_cur || ((depth_reg != '0) && match.zero1_f);
    assign h1_idx   = h1_cur ? match.cur1     : match.zero1;
    assign h1_fn    = h1_cur ? match.cur1_fn  : match.zero1_fn;
    assign h1_val   = h1_cur ? match.cur1_val : match.zero1_val;
    assign h1_level = h1_cur ? depth_reg      : '0;

    // Second lookup, with the first hit already dropped.
    always_comb begin
        hit2_cur = match.cur1_f && match.cur2_f;
        hit2_f   = hit2_cur;
        hit2_idx = match.cur2;
        if (!hit2_cur && (depth_reg != '0)) begin
            if (h1_f && !h1_cur) begin
                hit2_f   = match.zero2_f;
                hit2_idx = match.zero2;
            end else begin
                hit2_f   = match.zero1_f;
                hit2_idx = match.zero1;
            end
        end
        hit2_level = hit2_cur ? depth_reg : '0;
    end

    // The dropped entry may be the lowest empty slot.
    always_comb begin
        free2_f   = match.free_f || h1_f;
        free2_idx = match.free_idx;
        if (h1_f && (!match.free_f || (h1_idx < match.free_idx))) begin
            free2_idx = h1_idx;
        end
    end

    always_comb begin
        res        = '0;
        depth_next = depth_reg;
        wr_en      = 1'b0;
        wr_addr    = match.free_idx;
        wr_data    = '0;
        clr_h1     = 1'b0;
        set_en     = 1'b0;
        set_idx    = match.free_idx;
        if (state_reg == ST_DECIDE) begin
            unique case (op_e'(op_reg))
                OP_PUSH: begin
                    if (depth_reg == MAX_DEPTH) begin
                        res.error = ERR_DEPTH;
                    end else begin
                        depth_next = depth_reg + 1'b1;
                    end
                end
                OP_POP: begin
                    if (depth_reg != '0) begin
                        depth_next = depth_reg - 1'b1;
                    end
                end
                OP_LOOKUP, OP_GET_OR_CREATE: begin
                    if (h1_f) begin
                        res.found       = 1'b1;
                        res.slot        = 5'(h1_idx);
                        res.value_out   = 16'(h1_val);
                        res.is_function = h1_fn;
                        res.entry_level = h1_level;
                    end else if (op_e'(op_reg) == OP_GET_OR_CREATE) begin
                        if (match.free_f) begin
                            wr_en           = 1'b1;
                            wr_data.func    = 1'b0;
                            wr_data.level   = depth_reg;
                            wr_data.key     = key_reg;
                            wr_data.value   = '0;
                            set_en          = 1'b1;
                            res.found       = 1'b1;
                            res.slot        = 5'(match.free_idx);
                            res.entry_level = depth_reg;
                        end else begin
                            res.error = ERR_FULL;
                        end
                    end
                end
                OP_DELETE: begin
                end
                OP_CREATE: begin
                    if (match.free_f) begin
                        wr_en           = 1'b1;
                        wr_data.func    = 1'b0;
                        wr_data.level   = depth_reg;
                        wr_data.key     = key_reg;
                        wr_data.value   = val_reg;
                        set_en          = 1'b1;
                        res.found       = 1'b1;
                        res.slot        = 5'(match.free_idx);
                        res.value_out   = 16'(val_reg);
                        res.entry_level = depth_reg;
                    end else begin
                        res.error = ERR_FULL;
                    end
                end
                OP_CREATE_FUNC: begin
                    clr_h1          = h1_f;
                    res.freed_valid = h1_f && h1_fn;
                    res.freed_node  = (h1_f && h1_fn) ? 16'(h1_val) : 16'd0;
                    wr_data.func    = 1'b1;
                    wr_data.key     = key_reg;
                    wr_data.value   = val_reg;
                    if (hit2_f) begin
                        wr_en           = 1'b1;
                        wr_addr         = hit2_idx;
                        wr_data.level   = hit2_level;
                        res.found       = 1'b1;
                        res.slot        = 5'(hit2_idx);
                        res.value_out   = 16'(val_reg);
                        res.is_function = 1'b1;
                        res.entry_level = hit2_level;
                    end else if (free2_f) begin
                        wr_en           = 1'b1;
                        wr_addr         = free2_idx;
                        wr_data.level   = depth_reg;
                        set_en          = 1'b1;
                        set_idx         = free2_idx;
                        res.found       = 1'b1;
                        res.slot        = 5'(free2_idx);
                        res.value_out   = 16'(val_reg);
                        res.is_function = 1'b1;
                        res.entry_level = depth_reg;
                    end else begin
                        res.error = ERR_FULL;
                    end
                end
                default: begin
                end
            endcase
        end
        res.depth_out = depth_next;
    end

    always_comb begin
        ram_req.rd_en   = issue;
        ram_req.rd_addr = cnt_reg[SLOT_W-1:0];
        ram_req.wr_en   = dec_go && wr_en;
        ram_req.wr_addr = wr_addr;
        ram_req.wr_data = wr_data;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op_e'(s_payload.operation))
                        OP_POP, OP_LOOKUP, OP_DELETE, OP_CREATE,
                        OP_GET_OR_CREATE, OP_CREATE_FUNC: state_next = ST_SCAN;
                        default:                          state_next = ST_DECIDE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CNT_W'(SLOTS)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            depth_reg  <= '0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            valid_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= issue;
            if (accept) begin
                cnt_reg <= '0;
            end else if (issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (dec_go) begin
                depth_reg <= depth_next;
            end
            if (scan_clr) begin
                valid_reg[rd_idx_reg] <= 1'b0;
            end
            if (dec_go && clr_h1) begin
                valid_reg[h1_idx] <= 1'b0;
            end
            if (dec_go && set_en) begin
                valid_reg[set_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_payload.operation;
            key_reg <= s_payload.key[KEY_BITS-1:0];
            val_reg <= s_payload.value_in[VALUE_BITS-1:0];
        end
        rd_idx_reg <= cnt_reg[SLOT_W-1:0];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/scoped_symbol_table.sv =====
// Push and the unused code skip the scan and go straight to the decide step; every
// other operation scans the table once, one slot at a time through the single RAM
// read port, before its result is given. An item is taken only when the previous
// one has left the controller, so one item is in work at a time.
// Reset (aresetn low at a clock edge) clears all valid marks together, sets the
// scope depth to zero and empties the result register; no clearing pass follows.
`default_nettype none

module scoped_symbol_table (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  scst_pkg::in_item_t   s_payload,
    output logic                 m_valid,
    input  wire                  m_ready,
    output scst_pkg::out_item_t  m_payload
);
    import scst_pkg::*;

    // The controller owns the sequencing: it accepts one transfer, walks every slot
    // through the entry RAM (push and the unused code skip this walk), then settles it
    // in the decide state, which writes the RAM, the valid marks and the depth.
    ram_req_t  ram_req;
    entry_t    rd_data;
    logic      res_valid;
    out_item_t res;
    logic      out_free;

    logic      m_valid_reg;
    out_item_t m_payload_reg;

    // The result register parts the two sides: while a result waits for
    // the consumer, the controller is already free to take the next input.
    assign out_free = !m_valid_reg || m_ready;

    scst_entry_ram u_ram (
        .aclk    (aclk),
        .ram_req (ram_req),
        .rd_data (rd_data)
    );

    scst_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_req   (ram_req),
        .rd_data   (rd_data)
    );

    // A result is loaded when the controller finishes and the register is
    // empty or being drained in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_payload_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/scst_checker.sv =====
`default_nettype none

module scst_checker (
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_valid,
    input wire                 s_ready,
    input wire                 m_valid,
    input wire                 m_ready,
    input scst_pkg::out_item_t m_payload
);
    import scst_pkg::*;

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    // Without an entry the entry fields are zero, and no freed node without a flag.
    a_clean_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.found |->
            m_payload.slot == 5'd0 && m_payload.value_out == 16'd0 &&
            !m_payload.is_function && m_payload.entry_level == 6'd0 &&
            (m_payload.freed_valid || m_payload.freed_node == 16'd0))
        else $error("miss carries entry data");

    // Errors agree with the other fields.
    a_error_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            (m_payload.error == ERR_NONE ||
             (m_payload.error == ERR_FULL && !m_payload.found) ||
             (m_payload.error == ERR_DEPTH && !m_payload.found &&
              m_payload.depth_out == 6'd63)))
        else $error("inconsistent error code");

endmodule

bind scoped_symbol_table scst_checker u_scst_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire

// ===== dv/tb_scoped_symbol_table.sv =====
module tb_scoped_symbol_table;

    import scst_pkg::*;

    // Code seven is not decoded by the block; it must leave the table alone.
    localparam logic [2:0] OP_SPARE = 3'd7;

    // QUIET_LIMIT is far longer than a long receiver hold-off plus the slowest
    // operation, so a stretch that long with no transfer on either side
    // can only mean the block has hung.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 3000;
    // After the last result, give a full scan time for anything unexpected.
    localparam int DRAIN_CYCLES    = 40;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_payload;

    // Results still owed by the block, oldest first.
    out_item_t owed_replies[$];
    int        fail_count   = 0;
    int        quiet_cycles = 0;

    // Knobs shared between the stimulus tasks and the receiver process.
    bit source_gaps_on = 1'b1;
    bit sink_gaps_on   = 1'b1;
    bit hold_off_req   = 1'b0;

    // Shadow copy of the symbol table. Only the valid marks and the depth
    // need a reset value; the other fields are read only while valid.
    bit     tbl_valid [SLOTS] = '{default: 1'b0};
    bit     tbl_func  [SLOTS];
    level_t tbl_level [SLOTS];
    key_t   tbl_key   [SLOTS];
    val_t   tbl_value [SLOTS];
    level_t scope_now = '0;

    // Keys reused by the random tests so that lookups and deletes hit.
    key_t key_pool [8];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    scoped_symbol_table uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // ------------------------------------------------------------------
    // Table shadow: search, allocation and the per-operation update.
    // ------------------------------------------------------------------

    function automatic int find_at(key_t k, level_t lv);
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && tbl_key[i] == k && tbl_level[i] == lv) begin
                return i;
            end
        end
        return -1;
    endfunction

    // The current scope wins; otherwise only the global scope is searched.
    function automatic int visible_slot(key_t k);
        int r;
        r = find_at(k, scope_now);
        if (r < 0 && scope_now != 0) begin
            r = find_at(k, '0);
        end
        return r;
    endfunction

    // Takes the lowest free slot at the current depth; no duplicate check.
    function automatic int claim_slot(key_t k, val_t v);
        for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_func[i]  = 1'b0;
                tbl_level[i] = scope_now;
                tbl_key[i]   = k;
                tbl_value[i] = v;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int resolve_or_claim(key_t k);
        int r;
        r = visible_slot(k);
        if (r < 0) begin
            r = claim_slot(k, '0);
        end
        return r;
    endfunction

    // Applies one symbol operation to the shadow table and returns the
    // reply the block must give for it.
    function automatic out_item_t apply_symbol_op(in_item_t it);
        out_item_t r;
        int        hit;
        bit        full;
        r    = '0;
        hit  = -1;
        full = 1'b0;
        case (it.operation)
            OP_PUSH: begin
                if (scope_now == MAX_DEPTH) begin
                    r.error = ERR_DEPTH;
                end else begin
                    scope_now++;
                end
            end
            OP_POP: begin
                // Even at depth zero the globals are swept away.
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_level[i] == scope_now) begin
                        tbl_valid[i] = 1'b0;
                    end
                end
                if (scope_now != 0) begin
                    scope_now--;
                end
            end
            OP_LOOKUP: begin
                hit = visible_slot(it.key);
            end
            OP_DELETE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_key[i] == it.key) begin
                        tbl_valid[i] = 1'b0;
                    end
                end
            end
            OP_CREATE: begin
                hit  = claim_slot(it.key, it.value_in);
                full = (hit < 0);
            end
            OP_GET_OR_CREATE: begin
                hit  = resolve_or_claim(it.key);
                full = (hit < 0);
            end
            OP_CREATE_FUNC: begin
                // Drop whatever is visible, remembering an old function body,
                // then resolve again: a global of the same key may now show.
                hit = visible_slot(it.key);
                if (hit >= 0) begin
                    if (tbl_func[hit]) begin
                        r.freed_valid = 1'b1;
                        r.freed_node  = tbl_value[hit];
                    end
                    tbl_valid[hit] = 1'b0;
                end
                hit = resolve_or_claim(it.key);
                if (hit < 0) begin
                    full = 1'b1;
                end else begin
                    tbl_func[hit]  = 1'b1;
                    tbl_value[hit] = it.value_in;
                end
            end
            default: begin
            end
        endcase
        if (full) begin
            r.error = ERR_FULL;
        end
        if (hit >= 0) begin
            r.found       = 1'b1;
            r.slot        = hit[4:0];
            r.value_out   = tbl_value[hit];
            r.is_function = tbl_func[hit];
            r.entry_level = tbl_level[hit];
        end
        r.depth_out = scope_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random choices.
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(12, 45);
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return OP_PUSH;
        if (r < 21) return OP_POP;
        if (r < 40) return OP_LOOKUP;
        if (r < 47) return OP_DELETE;
        if (r < 62) return OP_CREATE;
        if (r < 77) return OP_GET_OR_CREATE;
        if (r < 97) return OP_CREATE_FUNC;
        return OP_SPARE;
    endfunction

    function automatic key_t pick_key();
        if ($urandom_range(0, 99) < 88) begin
            return key_pool[$urandom_range(0, 7)];
        end
        return key_t'($urandom);
    endfunction

    function automatic val_t any_value();
        return val_t'($urandom);
    endfunction

    task automatic refresh_pool();
        foreach (key_pool[i]) begin
            key_pool[i] = key_t'($urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offers one item and returns in the time step of its transfer. Valid is
    // left high, so a following call without a gap keeps the channel busy;
    // it is lowered only by a gap or by a pause for the table to drain.
    task automatic send_item(input logic [2:0] op, input key_t k, input val_t v);
        in_item_t item;
        int       gap;
        item.operation = op;
        item.key       = k;
        item.value_in  = v;
        gap = source_gaps_on ? idle_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        owed_replies.push_back(apply_symbol_op(item));
    endtask

    task automatic send_random();
        send_item(pick_op(), pick_key(), any_value());
    endtask

    // The sender goes quiet until every owed result has been seen.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (owed_replies.size() != 0);
    endtask

    // Popping every open level and then once more at depth zero empties the
    // whole table, since no entry can sit above the current depth.
    task automatic empty_table();
        while (scope_now != 0) begin
            send_item(OP_POP, key_t'($urandom), any_value());
        end
        send_item(OP_POP, key_t'($urandom), any_value());
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Field extremes, every operation and the corner cases of scoping,
    // replacement of function entries and the undecoded code.
    task automatic test_directed();
        send_item(OP_LOOKUP, '0, '0);                        // empty table miss
        send_item(OP_POP, '1, '1);                           // pop with nothing open
        send_item(OP_CREATE, '1, '1);
        send_item(OP_CREATE, '0, '0);
        send_item(OP_CREATE_FUNC, '1, 16'h1234);             // replaces a plain entry
        send_item(OP_CREATE_FUNC, '1, 16'hABCD);             // old function is freed
        send_item(OP_PUSH, 24'h5A5A5A, 16'hA5A5);
        send_item(OP_LOOKUP, '1, '0);                        // falls back to globals
        send_item(OP_CREATE, '1, 16'h0007);                  // shadows the global
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_GET_OR_CREATE, 24'h800000, 16'hFFFF);   // creates
        send_item(OP_GET_OR_CREATE, 24'h800000, '0);         // finds
        send_item(OP_CREATE_FUNC, '0, 16'h8000);             // global dropped, local made
        send_item(OP_DELETE, '1, '0);                        // all levels
        send_item(OP_SPARE, 24'hC3C3C3, 16'h3C3C);
        send_item(OP_POP, '0, '0);
        send_item(OP_LOOKUP, 24'h800000, '0);
        send_item(OP_POP, '0, '0);                           // wipes the globals
        send_item(OP_CREATE_FUNC, 24'h555555, 16'h00FF);     // fresh global function
        send_item(OP_PUSH, '0, '0);
        send_item(OP_CREATE, 24'h555555, 16'h0003);
        // The local copy is dropped and the global function is found again.
        send_item(OP_CREATE_FUNC, 24'h555555, 16'hFF00);
        send_item(OP_LOOKUP, 24'h555555, '0);
        send_item(OP_POP, '0, '0);
        send_item(OP_POP, '0, '0);
    endtask

    // Climbs to the deepest scope, pushes past it, and comes back down,
    // with symbol traffic on the way.
    task automatic test_depth_limit();
        refresh_pool();
        while (scope_now != MAX_DEPTH) begin
            send_item(OP_PUSH, key_t'($urandom), any_value());
            if ($urandom_range(0, 5) == 0) begin
                send_item(OP_GET_OR_CREATE, pick_key(), any_value());
            end
        end
        repeat (4) send_item(OP_PUSH, key_t'($urandom), any_value());
        repeat (6) send_item(OP_CREATE_FUNC, pick_key(), any_value());
        repeat (4) send_item(OP_LOOKUP, pick_key(), any_value());
        while (scope_now != 0) begin
            send_item(OP_POP, key_t'($urandom), any_value());
            if ($urandom_range(0, 6) == 0) begin
                send_item(OP_LOOKUP, pick_key(), any_value());
            end
        end
        send_item(OP_POP, key_t'($urandom), any_value());
    endtask

    // Fills every slot across two scopes and then hits each allocating
    // operation against the full table.
    task automatic test_table_full();
        refresh_pool();
        empty_table();
        repeat (20) send_item(OP_CREATE, pick_key(), any_value());
        send_item(OP_PUSH, '0, '0);
        repeat (16) send_item(OP_CREATE, pick_key(), any_value());
        send_item(OP_GET_OR_CREATE, key_t'($urandom), any_value());
        send_item(OP_GET_OR_CREATE, key_pool[0], any_value());
        send_item(OP_CREATE_FUNC, key_pool[1], any_value());
        send_item(OP_CREATE_FUNC, key_t'($urandom), any_value());
        send_item(OP_CREATE, key_t'($urandom), any_value());
        send_item(OP_DELETE, key_pool[2], any_value());
        repeat (3) send_item(OP_CREATE, pick_key(), any_value());
        repeat (4) send_item(OP_LOOKUP, pick_key(), any_value());
        empty_table();
    endtask

    // The receiver stops for a long stretch while the sender keeps offering,
    // so the result register and the scan both back up into the input.
    task automatic test_backpressure();
        source_gaps_on = 1'b0;
        hold_off_req   = 1'b1;
        repeat (30) send_random();
        wait_drained();
        source_gaps_on = 1'b1;
    endtask

    // Bulk random traffic over a key pool that changes every hundred
    // transfers; one block of it runs with both sides flat out.
    task automatic test_random_mix();
        for (int chunk = 0; chunk < 16; chunk++) begin
            refresh_pool();
            source_gaps_on = (chunk != 6);
            sink_gaps_on   = (chunk != 6);
            repeat (100) send_random();
        end
        source_gaps_on = 1'b1;
        sink_gaps_on   = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: ready with random gaps, and a long hold-off on demand.
    // ------------------------------------------------------------------

    initial begin : reply_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                m_ready <= 1'b1;
            end else if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if (sink_gaps_on) begin
                    hold = idle_length();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Outputs are sampled at the clock edge, before the block updates them.
    always @(posedge aclk) begin : reply_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_replies.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual %h",
                         $time, m_payload);
                fail_count++;
            end else begin
                want = owed_replies.pop_front();
                compare_field("found",       want.found,       m_payload.found);
                compare_field("slot",        want.slot,        m_payload.slot);
                compare_field("value_out",   want.value_out,   m_payload.value_out);
                compare_field("is_function", want.is_function, m_payload.is_function);
                compare_field("entry_level", want.entry_level, m_payload.entry_level);
                compare_field("freed_valid", want.freed_valid, m_payload.freed_valid);
                compare_field("freed_node",  want.freed_node,  m_payload.freed_node);
                compare_field("error",       want.error,       m_payload.error);
                compare_field("depth_out",   want.depth_out,   m_payload.depth_out);
            end
        end
    end

    // Watchdog: any transfer on either channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, owed_replies.size());
                $display("[scoped_symbol_table] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        wait_drained();
        test_depth_limit();
        wait_drained();
        test_table_full();
        wait_drained();
        test_backpressure();
        test_random_mix();
        wait_drained();

        // Leave room for a stray result after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && owed_replies.size() == 0) begin
            $display("[scoped_symbol_table] OK");
        end else begin
            $display("[scoped_symbol_table] ERROR");
        end
        $finish;
    end

endmodule

// ===== scoped_symbol_table.f =====
hw/rtl/scst_pkg.sv
hw/rtl/scst_entry_ram.sv
hw/rtl/scst_match.sv
hw/rtl/scst_ctrl.sv
hw/rtl/scoped_symbol_table.sv
hw/rtl/scst_checker.sv
dv/tb_scoped_symbol_table.sv
